>>> rtl/core/rle8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder package
// Shared constants, types and helper functions of the RLE8 bitmap decoder.
// ----------------------------------------------------------------------------
package rle8d_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int BYTE_W    = 8;
	localparam int OFS_W     = 24;

	localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 256 * MAX_WIDTH + 256);
	localparam int STEP_W = $clog2(POS_W);
	localparam int DMUL_W = DIM_W + BYTE_W;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	localparam logic [BYTE_W-1:0] ESC_EOL   = BYTE_W'(0);
	localparam logic [BYTE_W-1:0] ESC_EOB   = BYTE_W'(1);
	localparam logic [BYTE_W-1:0] ESC_DELTA = BYTE_W'(2);
	localparam logic [BYTE_W-1:0] ESC_MARK  = BYTE_W'(0);

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_VALUE,
		PH_ESCAPE,
		PH_DRIGHT,
		PH_DDOWN,
		PH_ABS,
		PH_PAD
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_EXEC,
		S_CHK,
		S_DIV,
		S_FIN,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_ALWAYS,
		EM_IF_DONE
	} emit_t;

	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] numer;
		logic [DIM_W-1:0] divisor;
	} unit_ctl_t;

	typedef struct packed {
		logic             done;
		logic [POS_W-1:0] rem;
	} unit_sts_t;

	function automatic logic [DIM_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if ((CFG_W + DIM_W)'(v) > (CFG_W + DIM_W)'(MAX_WIDTH)) begin
			r = DIM_W'(MAX_WIDTH);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
		logic [HGT_W-1:0] r;
		if (v == '0) begin
			r = HGT_W'(1);
		end else if ((CFG_W + HGT_W)'(v) > (CFG_W + HGT_W)'(MAX_HEIGHT)) begin
			r = HGT_W'(MAX_HEIGHT);
		end else begin
			r = HGT_W'(v);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/rle8_bitmap_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder core
// Parses an RLE8 compressed bitmap one byte per item and issues pixel run
// write commands with row tracking, delta skips and clipping at image end.
// ----------------------------------------------------------------------------
// After acceptance an item passes the prep, execute, check and finish states
// before ready returns, plus an emit state that waits to load the output
// register when it gives a result. A step past the current row runs the row
// unit, one quotient bit per cycle over the 25-bit position.
// Reset clears the parser to expect a first byte at offset zero and sets the
// width and height registers to 1.
module rle8_bitmap_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        encoded_byte,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [23:0]                       pixel_offset,
	output logic [7:0]                        pixel_value,
	output logic [7:0]                        run_length,
	output logic                              image_done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rle8d_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rle8d_pkg::CFG_W-1:0]       cfg_data
);

	rle8d_pkg::state_t state_q, state_n;

	logic [rle8d_pkg::CFG_W-1:0]  width_q, height_q;
	logic [rle8d_pkg::DIM_W-1:0]  wc;
	logic [rle8d_pkg::HGT_W-1:0]  hc;

	rle8d_pkg::phase_t phase_q, phase_n;
	logic [rle8d_pkg::POS_W-1:0]  wo_q, wo_n;
	logic [rle8d_pkg::POS_W-1:0]  rs_q, rs_n;
	logic [rle8d_pkg::BYTE_W-1:0] run_q, run_n;
	logic [rle8d_pkg::BYTE_W-1:0] dright_q, dright_n;
	logic                         pad_q, pad_n;
	logic                         fin_q, fin_n;

	logic [rle8d_pkg::BYTE_W-1:0]  byte_q;
	logic [rle8d_pkg::POS_W-1:0]   total_q;
	logic [rle8d_pkg::DMUL_W-1:0]  dmul_q;
	logic                          settle_q, settle_n;
	logic                          div_used_q;
	rle8d_pkg::emit_t              emit_q, emit_n;
	logic [rle8d_pkg::POS_W-1:0]   em_off_q, em_off_n;
	logic [rle8d_pkg::BYTE_W-1:0]  em_val_q, em_val_n;
	logic [rle8d_pkg::BYTE_W-1:0]  em_len_q, em_len_n;
	logic                          em_done_q;

	logic                          out_valid_q;
	logic [rle8d_pkg::OFS_W-1:0]   pix_off_q;
	logic [rle8d_pkg::BYTE_W-1:0]  pix_val_q;
	logic [rle8d_pkg::BYTE_W-1:0]  run_len_q;
	logic                          img_done_q;

	logic [rle8d_pkg::POS_W-1:0]  left;
	logic [rle8d_pkg::BYTE_W-1:0] run_len_clip;
	logic [rle8d_pkg::BYTE_W-1:0] run_dec;
	logic                         past_row;
	logic                         over;
	logic                         fin_after;
	logic [rle8d_pkg::POS_W-1:0]  rs_base;
	logic                         emit_go;
	logic                         in_take;
	logic                         out_load;

	rle8d_pkg::unit_ctl_t unit_ctl;
	rle8d_pkg::unit_sts_t unit_sts;

	rle8d_row_unit u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (unit_ctl),
		.sts    (unit_sts)
	);

	assign wc = rle8d_pkg::clamp_width(width_q);
	assign hc = rle8d_pkg::clamp_height(height_q);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rle8d_pkg::CFG_W'(1);
			height_q <= rle8d_pkg::CFG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rle8d_pkg::REG_WIDTH:  width_q  <= cfg_data;
				rle8d_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parser step for the accepted byte.
	assign left         = total_q - wo_q;
	assign run_len_clip = (rle8d_pkg::POS_W'(run_q) > left) ?
		left[rle8d_pkg::BYTE_W-1:0] : run_q;
	assign run_dec      = (run_q != '0) ? run_q - 1'b1 : run_q;

	always_comb begin
		phase_n  = phase_q;
		wo_n     = wo_q;
		rs_n     = rs_q;
		run_n    = run_q;
		dright_n = dright_q;
		pad_n    = pad_q;
		fin_n    = fin_q;
		settle_n = 1'b0;
		emit_n   = rle8d_pkg::EM_NONE;
		em_off_n = wo_q;
		em_val_n = byte_q;
		em_len_n = '0;
		if (fin_q) begin
		end else if (wo_q >= total_q) begin
			wo_n  = total_q;
			fin_n = 1'b1;
		end else begin
			unique case (phase_q)
				rle8d_pkg::PH_FIRST: begin
					if (byte_q == rle8d_pkg::ESC_MARK) begin
						phase_n = rle8d_pkg::PH_ESCAPE;
					end else begin
						run_n   = byte_q;
						phase_n = rle8d_pkg::PH_VALUE;
					end
				end
				rle8d_pkg::PH_VALUE: begin
					wo_n     = wo_q + rle8d_pkg::POS_W'(run_len_clip);
					run_n    = '0;
					phase_n  = rle8d_pkg::PH_FIRST;
					settle_n = 1'b1;
					emit_n   = rle8d_pkg::EM_ALWAYS;
					em_len_n = run_len_clip;
				end
				rle8d_pkg::PH_ESCAPE: begin
					if (byte_q == rle8d_pkg::ESC_EOL) begin
						wo_n     = rs_q + rle8d_pkg::POS_W'(wc);
						rs_n     = rs_q + rle8d_pkg::POS_W'(wc);
						phase_n  = rle8d_pkg::PH_FIRST;
						settle_n = 1'b1;
						emit_n   = rle8d_pkg::EM_IF_DONE;
						em_off_n = total_q;
						em_val_n = '0;
					end else if (byte_q == rle8d_pkg::ESC_EOB) begin
						fin_n    = 1'b1;
						phase_n  = rle8d_pkg::PH_FIRST;
						emit_n   = rle8d_pkg::EM_ALWAYS;
						em_val_n = '0;
					end else if (byte_q == rle8d_pkg::ESC_DELTA) begin
						phase_n = rle8d_pkg::PH_DRIGHT;
					end else begin
						run_n   = byte_q;
						pad_n   = byte_q[0];
						phase_n = rle8d_pkg::PH_ABS;
					end
				end
				rle8d_pkg::PH_DRIGHT: begin
					dright_n = byte_q;
					phase_n  = rle8d_pkg::PH_DDOWN;
				end
				rle8d_pkg::PH_DDOWN: begin
					wo_n     = wo_q + rle8d_pkg::POS_W'(dright_q) +
						rle8d_pkg::POS_W'(dmul_q);
					rs_n     = rs_q + rle8d_pkg::POS_W'(dmul_q);
					dright_n = '0;
					phase_n  = rle8d_pkg::PH_FIRST;
					settle_n = 1'b1;
					emit_n   = rle8d_pkg::EM_IF_DONE;
					em_off_n = total_q;
					em_val_n = '0;
				end
				rle8d_pkg::PH_ABS: begin
					wo_n  = wo_q + rle8d_pkg::POS_W'(1);
					run_n = run_dec;
					if (run_dec == '0) begin
						phase_n = pad_q ? rle8d_pkg::PH_PAD : rle8d_pkg::PH_FIRST;
						pad_n   = 1'b0;
					end
					settle_n = 1'b1;
					emit_n   = rle8d_pkg::EM_ALWAYS;
					em_len_n = rle8d_pkg::BYTE_W'(1);
				end
				rle8d_pkg::PH_PAD: begin
					phase_n = rle8d_pkg::PH_FIRST;
				end
				default: begin
					phase_n = rle8d_pkg::PH_FIRST;
				end
			endcase
		end
	end

	// Row tracking and clipping after the step.
	assign past_row  = {1'b0, wo_q} > ({1'b0, rs_q} + (rle8d_pkg::POS_W + 1)'(wc));
	assign over      = wo_q >= total_q;
	assign fin_after = settle_q ? (fin_q | over) : fin_q;
	assign rs_base   = div_used_q ? (wo_q - rle8d_pkg::POS_W'(1) - unit_sts.rem) : rs_q;
	assign emit_go   = (emit_q == rle8d_pkg::EM_ALWAYS) ||
		((emit_q == rle8d_pkg::EM_IF_DONE) && fin_after);

	always_comb begin
		in_take          = 1'b0;
		out_load         = 1'b0;
		unit_ctl.start   = 1'b0;
		unit_ctl.numer   = wo_q - rs_q - rle8d_pkg::POS_W'(1);
		unit_ctl.divisor = wc;
		unique case (state_q)
			rle8d_pkg::S_IDLE: in_take        = in_valid;
			rle8d_pkg::S_CHK:  unit_ctl.start = settle_q && past_row;
			rle8d_pkg::S_EMIT: out_load       = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rle8d_pkg::S_IDLE: if (in_valid) state_n = rle8d_pkg::S_PREP;
			rle8d_pkg::S_PREP: state_n = rle8d_pkg::S_EXEC;
			rle8d_pkg::S_EXEC: state_n = rle8d_pkg::S_CHK;
			rle8d_pkg::S_CHK: begin
				state_n = unit_ctl.start ? rle8d_pkg::S_DIV : rle8d_pkg::S_FIN;
			end
			rle8d_pkg::S_DIV: if (unit_sts.done) state_n = rle8d_pkg::S_FIN;
			rle8d_pkg::S_FIN: begin
				state_n = emit_go ? rle8d_pkg::S_EMIT : rle8d_pkg::S_IDLE;
			end
			rle8d_pkg::S_EMIT: if (out_load) state_n = rle8d_pkg::S_IDLE;
			default: state_n = rle8d_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rle8d_pkg::S_IDLE;
			phase_q    <= rle8d_pkg::PH_FIRST;
			wo_q       <= '0;
			rs_q       <= '0;
			run_q      <= '0;
			dright_q   <= '0;
			pad_q      <= 1'b0;
			fin_q      <= 1'b0;
			settle_q   <= 1'b0;
			div_used_q <= 1'b0;
			emit_q     <= rle8d_pkg::EM_NONE;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				rle8d_pkg::S_IDLE: begin
					if (in_take && frame_start) begin
						phase_q  <= rle8d_pkg::PH_FIRST;
						wo_q     <= '0;
						rs_q     <= '0;
						run_q    <= '0;
						dright_q <= '0;
						pad_q    <= 1'b0;
						fin_q    <= 1'b0;
					end
				end
				rle8d_pkg::S_EXEC: begin
					phase_q    <= phase_n;
					wo_q       <= wo_n;
					rs_q       <= rs_n;
					run_q      <= run_n;
					dright_q   <= dright_n;
					pad_q      <= pad_n;
					fin_q      <= fin_n;
					settle_q   <= settle_n;
					emit_q     <= emit_n;
					div_used_q <= 1'b0;
				end
				rle8d_pkg::S_CHK: begin
					div_used_q <= unit_ctl.start;
				end
				rle8d_pkg::S_FIN: begin
					if (settle_q) begin
						wo_q  <= over ? total_q : wo_q;
						fin_q <= fin_after;
						rs_q  <= (rs_base > total_q) ? total_q : rs_base;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_q <= encoded_byte;
		end
		if (state_q == rle8d_pkg::S_PREP) begin
			total_q <= rle8d_pkg::POS_W'(wc) * rle8d_pkg::POS_W'(hc);
			dmul_q  <= rle8d_pkg::DMUL_W'(byte_q) * rle8d_pkg::DMUL_W'(wc);
		end
		if (state_q == rle8d_pkg::S_EXEC) begin
			em_off_q <= em_off_n;
			em_val_q <= em_val_n;
			em_len_q <= em_len_n;
		end
		if (state_q == rle8d_pkg::S_FIN) begin
			em_done_q <= fin_after;
		end
		if (out_load) begin
			pix_off_q  <= em_off_q[rle8d_pkg::OFS_W-1:0];
			pix_val_q  <= em_val_q;
			run_len_q  <= em_len_q;
			img_done_q <= em_done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready     = (state_q == rle8d_pkg::S_IDLE);
	assign out_valid    = out_valid_q;
	assign pixel_offset = pix_off_q;
	assign pixel_value  = pix_val_q;
	assign run_length   = run_len_q;
	assign image_done   = img_done_q;

endmodule

>>> rtl/core/rle8d_row_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE8 decoder row unit
// Shift-subtract remainder unit, one quotient bit per cycle, used to snap the
// row start onto the row of the position just before the write cursor.
// ----------------------------------------------------------------------------
module rle8d_row_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rle8d_pkg::unit_ctl_t ctl,
	output rle8d_pkg::unit_sts_t sts
);

	logic                                        busy_q;
	logic                                        done_q;
	logic [rle8d_pkg::STEP_W-1:0]                step_q;
	logic [rle8d_pkg::POS_W-1:0]                 rem_q;
	logic [rle8d_pkg::DIM_W-1:0]                 div_q;
	logic [rle8d_pkg::POS_W+rle8d_pkg::DIM_W-1:0] shifted;
	logic                                        fits;

	assign shifted = (rle8d_pkg::POS_W + rle8d_pkg::DIM_W)'(div_q) << step_q;
	assign fits    = shifted <= (rle8d_pkg::POS_W + rle8d_pkg::DIM_W)'(rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= rle8d_pkg::STEP_W'(rle8d_pkg::POS_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= ctl.numer;
			div_q <= ctl.divisor;
		end else if (busy_q && fits) begin
			rem_q <= rem_q - shifted[rle8d_pkg::POS_W-1:0];
		end
	end

	assign sts.done = done_q;
	assign sts.rem  = rem_q;

endmodule

>>> rtl/core/rle8d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE8 decoder port checker
// Watches the ports of the decoder core and flags illegal behavior over time.
// ----------------------------------------------------------------------------
module rle8d_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [23:0]                     pixel_offset,
	input logic [7:0]                      pixel_value,
	input logic [7:0]                      run_length,
	input logic                            image_done
);

	// A waiting result item holds its payload until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_offset) &&
			$stable(pixel_value) && $stable(run_length) && $stable(image_done))
		else $error("result item changed while stalled");

	// The core works on one item at a time.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in work");

	// No result can appear in the cycle right after an item is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// Zero-length results only mark the end of an image.
	a_zero_len_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_length == 8'd0 |-> image_done)
		else $error("empty run without end of image");

endmodule

bind rle8_bitmap_decoder_core rle8d_checker u_rle8d_checker (.*);
